// ===== design/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types and constants for the thermistor divider linearizer
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_READING = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  localparam logic [2:0] REG_DIVIDER = 3'd0;
  localparam logic [2:0] REG_SUPPLY = 3'd1;
  localparam logic [2:0] REG_COEFF_A = 3'd2;
  localparam logic [2:0] REG_COEFF_B = 3'd3;
  localparam logic [2:0] REG_COEFF_C = 3'd4;

  // bounds on the steinhart-hart sum that keep the result within -40..600 f
  localparam logic signed [127:0] N_MAX = 128'((128'd100 << 60) / 128'd23315);
  localparam logic signed [127:0] N_MIN =
    128'(((128'd900 << 60) + 128'd529834) / 128'd529835);

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic [16:0] sample;
    logic [16:0] denom;
    logic        reject;
  } tdc_item_t;

endpackage

// ===== design/thermistor_divider_to_celsius_core.sv =====
// ----------------------------------------------------------------------------
// thermistor_divider_to_celsius_core
// divider voltage to probe resistance and temperature
// ----------------------------------------------------------------------------
// latency depends on the path: a rejected sample goes from the queue straight to the
// finishing state, an accepted one through the serial dividers, the log unit and multipliers
// a two-entry queue takes new words meanwhile; busy is high while it is full
// results are never held off
// synchronous reset restores register defaults and empties the queue
module thermistor_divider_to_celsius_core import tdc_pkg::*; #(
  parameter int LN_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [16:0]        sample_mv_x16,
  output logic               done,
  output logic signed [15:0] temp_centi_c,
  output logic [31:0]        resistance_ohms,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [19:0]        divider_ohms;
  logic [12:0]        supply_mv;
  logic signed [47:0] coeff_a;
  logic signed [47:0] coeff_b;
  logic signed [47:0] coeff_c;
  logic               full;
  logic               avail;
  logic               pop;
  tdc_item_t          head;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign busy = full;
  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ohms <= 20'd10000;
      supply_mv <= 13'd3300;
      coeff_a <= '0;
      coeff_b <= '0;
      coeff_c <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_DIVIDER: divider_ohms <= pwdata[19:0];
        REG_SUPPLY: supply_mv <= pwdata[12:0];
        REG_COEFF_A: coeff_a <= pwdata[47:0];
        REG_COEFF_B: coeff_b <= pwdata[47:0];
        REG_COEFF_C: coeff_c <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIVIDER: prdata = 64'(divider_ohms);
      REG_SUPPLY: prdata = 64'(supply_mv);
      REG_COEFF_A: prdata = 64'(coeff_a);
      REG_COEFF_B: prdata = 64'(coeff_b);
      REG_COEFF_C: prdata = 64'(coeff_c);
      default: prdata = '0;
    endcase
  end

  tdc_front u_front (
    .clk(clk), .rst(rst), .start(start), .sample_mv_x16(sample_mv_x16),
    .supply_mv(supply_mv), .pop(pop), .full(full), .avail(avail), .head(head)
  );

  tdc_back #(.LN_FRAC_BITS(LN_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .divider_ohms(divider_ohms),
    .coeff_a(coeff_a), .coeff_b(coeff_b), .coeff_c(coeff_c), .pop(pop),
    .done(done), .temp_centi_c(temp_centi_c), .resistance_ohms(resistance_ohms),
    .status(status)
  );

endmodule

// ===== design/tdc_front.sv =====
// ----------------------------------------------------------------------------
// tdc_front
// accepts samples, flags readings that cannot come from a probe and
// queues each accepted sample, flagged or not, for the back part
// ----------------------------------------------------------------------------
module tdc_front import tdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [16:0]      sample_mv_x16,
  input  logic [12:0]      supply_mv,
  input  logic             pop,
  output logic             full,
  output logic             avail,
  output tdc_item_t        head
);

  tdc_item_t   q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic [16:0] v16;
  logic [23:0] lhs;
  logic [23:0] rhs;
  tdc_item_t   item;

  assign full = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign push = start && !full;
  assign head = q[rd_ptr];

  always_comb begin
    v16 = {supply_mv, 4'b0000};
    lhs = 24'(sample_mv_x16) * 24'd100;
    rhs = 24'(supply_mv) * 24'd1616;
    item.sample = sample_mv_x16;
    item.denom = v16 - sample_mv_x16;
    item.reject = (sample_mv_x16 == 17'd0) || (lhs > rhs) ||
                  ({1'b0, v16} < (18'(sample_mv_x16) + 18'd32));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/tdc_back.sv =====
// ----------------------------------------------------------------------------
// tdc_back
// sequencer that turns one screened sample into resistance and temperature
// through two serial dividers, a log unit and multipliers
// ----------------------------------------------------------------------------
module tdc_back import tdc_pkg::*; #(
  parameter int LN_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  tdc_item_t          head,
  input  logic [19:0]        divider_ohms,
  input  logic signed [47:0] coeff_a,
  input  logic signed [47:0] coeff_b,
  input  logic signed [47:0] coeff_c,
  output logic               pop,
  output logic               done,
  output logic signed [15:0] temp_centi_c,
  output logic [31:0]        resistance_ohms,
  output logic [1:0]         status
);

  localparam int LW = LN_FRAC_BITS + 6;
  localparam int L2W = LN_FRAC_BITS + 9;
  localparam int L3W = LN_FRAC_BITS + 14;
  localparam int PW = L3W + 26;

  typedef enum logic [3:0] {
    S_IDLE, S_RDIV, S_LOGN, S_LOG, S_LN, S_L2, S_L3, S_BLO, S_BHI, S_CLO, S_CHI,
    S_CADD, S_CHK, S_TDIV, S_FIN
  } state_t;

  state_t            state;
  logic [6:0]        cnt;
  logic [36:0]       rq;
  logic [16:0]       rrem;
  logic [16:0]       den;
  logic [31:0]       res;
  logic [4:0]        k;
  logic [31:0]       m;
  logic [31:0]       frac;
  logic [LW-1:0]     lval;
  logic [L2W-1:0]    l2;
  logic [L3W-1:0]    l3;
  logic signed [127:0] n;
  logic signed [127:0] acc;
  logic [52:0]       dv;
  logic [53:0]       trem;
  logic [66:0]       tq;
  logic [66:0]       num;
  logic [63:0]       ln32;
  logic [63:0]       msq;
  logic [17:0]       rtrial;
  logic [54:0]       ttrial;
  logic [4:0]        msb;
  logic [L2W-1:0]    sq_a;
  logic [L2W+LW-1:0] sq;
  logic              use_b;
  logic              use_lo;
  logic signed [47:0] cf;
  logic signed [24:0] cf_half;
  logic [L3W-1:0]    mx;
  logic signed [PW-1:0] mp;

  assign num = {7'd100, 60'd0};
  assign msq = 64'(m) * 64'(m);
  assign rtrial = {rrem, rq[36]};
  assign ttrial = {trem, num[66 - cnt]};
  assign sq_a = (state == S_L2) ? L2W'(lval) : l2;
  assign sq = (L2W+LW)'(sq_a) * (L2W+LW)'(lval);
  assign ln32 = 64'(k) * 64'(LN2_Q32) + ((64'(frac) * 64'(LN2_Q32)) >> 32);

  // coefficient times log term, one 24-bit half of the coefficient per cycle
  assign use_b = state inside {S_BLO, S_BHI};
  assign use_lo = state inside {S_BLO, S_CLO};
  assign cf = use_b ? coeff_b : coeff_c;
  assign cf_half = use_lo ? {1'b0, cf[23:0]} : {cf[47], cf[47:24]};
  assign mx = use_b ? L3W'(lval) : l3;
  assign mp = PW'(cf_half) * $signed({1'b0, mx});

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (res[i]) msb = 5'(i);
    end
  end

  assign pop = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (avail) begin
            resistance_ohms <= '0;
            temp_centi_c <= '0;
            if (head.reject) begin
              status <= ST_NO_READING;
              state <= S_FIN;
            end else begin
              status <= ST_OUT_OF_RANGE;
              rq <= 37'(head.sample) * 37'(divider_ohms);
              den <= head.denom;
              rrem <= '0;
              cnt <= '0;
              state <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (rtrial >= {1'b0, den}) begin
            rrem <= 17'(rtrial - {1'b0, den});
            rq <= {rq[35:0], 1'b1};
          end else begin
            rrem <= 17'(rtrial);
            rq <= {rq[35:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd36) state <= S_LOGN;
        end
        S_LOGN: begin
          res <= (rq[36:32] != 5'd0) ? 32'hFFFFFFFF : rq[31:0];
          resistance_ohms <= (rq[36:32] != 5'd0) ? 32'hFFFFFFFF : rq[31:0];
          state <= S_LOG;
          cnt <= 7'd0;
          if (rq == 37'd0) state <= S_FIN;
        end
        S_LOG: begin
          if (cnt == 7'd0) begin
            k <= msb;
            m <= 32'({res, 30'd0} >> msb);
            frac <= '0;
          end else begin
            if (msq[61]) begin
              m <= 32'(msq >> 31);
              frac[32 - cnt] <= 1'b1;
            end else begin
              m <= 32'(msq >> 30);
            end
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd32) state <= S_LN;
        end
        S_LN: begin
          lval <= LW'(ln32 >> (32 - LN_FRAC_BITS));
          state <= S_L2;
        end
        S_L2: begin
          l2 <= L2W'(sq >> LN_FRAC_BITS);
          state <= S_L3;
        end
        S_L3: begin
          l3 <= L3W'(sq >> LN_FRAC_BITS);
          n <= 128'(coeff_a) <<< 16;
          state <= S_BLO;
        end
        S_BLO: begin
          acc <= 128'(mp);
          state <= S_BHI;
        end
        S_BHI: begin
          acc <= acc + (128'(mp) <<< 24);
          state <= S_CLO;
        end
        S_CLO: begin
          n <= n + (acc >>> (LN_FRAC_BITS - 16));
          acc <= 128'(mp);
          state <= S_CHI;
        end
        S_CHI: begin
          acc <= acc + (128'(mp) <<< 24);
          state <= S_CADD;
        end
        S_CADD: begin
          n <= n + (acc >>> LN_FRAC_BITS);
          state <= S_CHK;
        end
        S_CHK: begin
          if (n < N_MIN || n > N_MAX) begin
            state <= S_FIN;
          end else begin
            dv <= 53'(n);
            trem <= '0;
            tq <= '0;
            cnt <= '0;
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (ttrial >= {2'b0, dv}) begin
            trem <= 54'(ttrial - {2'b0, dv});
            tq <= {tq[65:0], 1'b1};
          end else begin
            trem <= 54'(ttrial);
            tq <= {tq[65:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd66) begin
            state <= S_FIN;
            status <= ST_OK;
            temp_centi_c <= 16'((({tq[65:0], 1'b0} | 67'(ttrial >= {2'b0, dv})) +
              67'((({1'b0, (ttrial >= {2'b0, dv}) ? 54'(ttrial - {2'b0, dv}) : 54'(ttrial)}
              << 1)) >= {2'b0, dv})) - 67'd27315);
          end
        end
        S_FIN: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/tdc_checker.sv =====
// ----------------------------------------------------------------------------
// tdc_checker
// port level checks for the linearizer
// ----------------------------------------------------------------------------
module tdc_checker import tdc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               done,
  input logic signed [15:0] temp_centi_c,
  input logic [31:0]        resistance_ohms,
  input logic [1:0]         status,
  input logic               pready
);

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_READING || status == ST_OUT_OF_RANGE))
    else $error("bad status");
  a_temp: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> temp_centi_c == 16'sd0) else $error("temp not zero");
  a_res: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NO_READING |-> resistance_ohms == 32'd0) else $error("res");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind thermistor_divider_to_celsius_core tdc_checker u_chk (
  .clk(clk), .rst(rst), .done(done), .temp_centi_c(temp_centi_c),
  .resistance_ohms(resistance_ohms), .status(status), .pready(pready)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// thermistor divider linearizer testbench
// drives divider samples through the command port, writes the divider, supply
// and coefficient registers over the register port between phases, and checks
// every result word against a bit-accurate predictor of resistance, log,
// steinhart-hart sum and rounded temperature
// ----------------------------------------------------------------------------
module tb_top;
  import tdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LNF = 24;
  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [16:0] sample_mv_x16 = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic busy, done, pready;
  logic signed [15:0] temp_centi_c;
  logic [31:0] resistance_ohms;
  logic [1:0] status;
  logic [63:0] prdata;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [31:0] res;
    logic [1:0] st;
  } reading_t;

  reading_t pending_readings[$];
  int errors = 0;
  int idle_cycles = 0;
  int pacing_on = 1;

  logic [19:0] div_ohms;
  logic [12:0] sup_mv;
  logic signed [47:0] ca, cb, cc;

  thermistor_divider_to_celsius_core #(.LN_FRAC_BITS(LNF)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] ln_q(input logic [31:0] r);
    int k;
    logic [63:0] m, frac, ln32;
    k = 0;
    frac = '0;
    for (int b = 0; b < 32; b++) if (r[b]) k = b;
    m = (k <= 30) ? (64'(r) << (30 - k)) : (64'(r) >> (k - 30));
    for (int i = 1; i <= 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[32 - i] = 1'b1;
      end
    end
    ln32 = 64'(k) * 64'(LN2_Q32) + ((frac * 64'(LN2_Q32)) >> 32);
    return ln32 >> (32 - LNF);
  endfunction

  function automatic reading_t convert_sample(input logic [16:0] s);
    reading_t o;
    logic [63:0] rr, lv, l2, l3, q, rem;
    logic signed [127:0] n;
    logic [127:0] num, t;
    o = '{temp: '0, res: '0, st: ST_NO_READING};
    if (s == 0 || 64'(s) * 100 > 64'(sup_mv) * 1616 || 64'(sup_mv) * 16 < 64'(s) + 32)
      return o;
    rr = (64'(s) * 64'(div_ohms)) / (64'(sup_mv) * 16 - 64'(s));
    if (rr > 64'hFFFFFFFF) rr = 64'hFFFFFFFF;
    o.res = rr[31:0];
    o.st = ST_OUT_OF_RANGE;
    if (rr == 0) return o;
    lv = ln_q(rr[31:0]);
    l2 = 64'((128'(lv) * 128'(lv)) >> LNF);
    l3 = 64'((128'(l2) * 128'(lv)) >> LNF);
    n = (128'(signed'(ca)) <<< 16)
      + ((128'(signed'(cb)) * signed'(128'(lv))) >>> (LNF - 16))
      + ((128'(signed'(cc)) * signed'(128'(l3))) >>> LNF);
    if (n <= 0) return o;
    num = 128'd100 << 60;
    t = 128'(n) * 23315;
    if (t > num) return o;
    t = 128'(n) * 529835;
    if (t < (128'd900 << 60)) return o;
    q = 64'(num / 128'(n));
    rem = 64'(num % 128'(n));
    if (128'(rem) * 2 >= 128'(n)) q++;
    o.temp = 16'(q - 27315);
    o.st = ST_OK;
    return o;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    case (idx)
      REG_DIVIDER: div_ohms = v[19:0];
      REG_SUPPLY:  sup_mv = v[12:0];
      REG_COEFF_A: ca = v[47:0];
      REG_COEFF_B: cb = v[47:0];
      default:     cc = v[47:0];
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_config(input logic [19:0] d, input logic [12:0] v,
                            input logic [47:0] a, b, c);
    drain();
    reg_write(REG_DIVIDER, 64'(d));
    reg_write(REG_SUPPLY, 64'(v));
    reg_write(REG_COEFF_A, 64'(a));
    reg_write(REG_COEFF_B, 64'(b));
    reg_write(REG_COEFF_C, 64'(c));
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(input logic [16:0] s);
    if (pacing_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start <= 1'b1;
    sample_mv_x16 <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(convert_sample(s));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    reading_t e;
    if (!rst) begin
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (done) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected word");
          errors++;
        end else begin
          e = pending_readings.pop_front();
          if (temp_centi_c !== e.temp) begin
            $error("temp_centi_c exp %0d got %0d", e.temp, temp_centi_c);
            errors++;
          end
          if (resistance_ohms !== e.res) begin
            $error("resistance_ohms exp %0d got %0d", e.res, resistance_ohms);
            errors++;
          end
          if (status !== e.st) begin
            $error("status exp %0d got %0d", e.st, status);
            errors++;
          end
        end
      end
    end
  end

  // typical 10k ntc: a=1.129e-3, b=2.341e-4, c=8.775e-8
  localparam logic [47:0] NTC_A = 48'd19861000000;
  localparam logic [47:0] NTC_B = 48'd4118000000;
  localparam logic [47:0] NTC_C = 48'd101170000000;

  typedef struct {
    logic [16:0] s;
    logic chk;
    reading_t exp_r;
  } vec_t;

  vec_t directed[] = '{
    '{17'd0, 1'b1, '{0, 0, ST_NO_READING}},
    '{17'd131071, 1'b1, '{0, 0, ST_NO_READING}},
    '{17'd52800, 1'b1, '{0, 0, ST_NO_READING}},
    '{17'd52769, 1'b1, '{0, 0, ST_NO_READING}},
    '{17'd52768, 1'b0, '0},
    '{17'd1, 1'b0, '0},
    '{17'd26400, 1'b1, '{0, 10000, ST_OUT_OF_RANGE}},
    '{17'd20000, 1'b0, '0},
    '{17'd40000, 1'b0, '0}
  };

  initial begin
    logic [16:0] s;
    reading_t p;
    div_ohms = 20'd10000;
    sup_mv = 13'd3300;
    ca = '0;
    cb = '0;
    cc = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) begin
      p = convert_sample(directed[i].s);
      if (directed[i].chk && p !== directed[i].exp_r) begin
        $error("directed row %0d predictor disagrees", i);
        errors++;
      end
      send_word(directed[i].s);
    end
    set_config(20'd10000, 13'd3300, NTC_A, NTC_B, NTC_C);
    for (int i = 0; i < 12; i++) send_word(17'($urandom_range(1, 52800)));
    set_config(20'd1, 13'd1000, 48'h7FFFFFFFFFFF, 48'h800000000000, 48'h7FFFFFFFFFFF);
    for (int i = 0; i < 6; i++) send_word(17'($urandom_range(0, 16200)));
    set_config(20'd1000000, 13'd8000, 48'h800000000000, 48'h7FFFFFFFFFFF, 48'h800000000000);
    send_word(17'd128000);
    send_word(17'd127968);
    send_word(17'd100);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 5)
        set_config(20'($urandom_range(1, 1000000)), 13'($urandom_range(1000, 8000)),
                   48'(signed'(NTC_A) + $signed($urandom_range(0, 2000000000)) - 1000000000),
                   48'(signed'(NTC_B) + $signed($urandom_range(0, 400000000)) - 200000000),
                   ($urandom_range(0, 7) == 0) ? {$urandom, 16'($urandom)} : NTC_C);
      else
        set_config(20'd10000, 13'($urandom_range(1000, 8000)), NTC_A, NTC_B, NTC_C);
      pacing_on = (ph < 6);
      for (int i = 0; i < 250; i++) begin
        case ($urandom_range(0, 9))
          0: s = 17'($urandom);
          1: s = 17'(sup_mv * 16 - $urandom_range(0, 40));
          default: s = 17'($urandom_range(1, sup_mv * 16 - 32));
        endcase
        send_word(s);
      end
    end
    start <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
